[src/fbat_pkg.sv]
// Shared constants for the block allocation table: sizes, operation kinds and status codes.
package fbat_pkg;

	localparam int TABLE_ENTRIES = 65536;
	localparam int ADDR_W = $clog2(TABLE_ENTRIES);
	// Entry count after the table-size clamp; holds fat_blocks * 2048 at the largest
	localparam int ENT_W = 17;

	localparam logic [15:0] END_MARK = 16'hFFFF;

	localparam logic [2:0] KIND_ALLOC      = 3'd0;
	localparam logic [2:0] KIND_RELEASE    = 3'd1;
	localparam logic [2:0] KIND_FREE_CHAIN = 3'd2;
	localparam logic [2:0] KIND_COUNT      = 3'd3;
	localparam logic [2:0] KIND_READ       = 3'd4;
	localparam logic [2:0] KIND_WRITE      = 3'd5;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOFREE = 3'd1;
	localparam logic [2:0] ST_PROT   = 3'd2;
	localparam logic [2:0] ST_RANGE  = 3'd3;
	localparam logic [2:0] ST_LOOP   = 3'd4;

	localparam logic CFG_BLOCK_SIZE = 1'b0;
	localparam logic CFG_FAT_BLOCKS = 1'b1;

	localparam logic [2:0] MAX_SIZE_CODE = 3'd4;

endpackage

[src/fbat_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module fbat_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/fat_block_allocation_table.sv]
// Block allocation table: link memory, sequencer for allocate scans and chain walks.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: block, link_value, offset; tuser: kind, want_position
//  m_*       out  m_tvalid/m_tready  tdata: block_out, amount, chain_count, status
//  cfg_*     in   cfg_we             cfg_index selects the register, cfg_data is the value
//
// Release, write link, position and range/protect rejects pass from accept through DISP to
// FIN; read link also passes READ_EV. Allocate scans entries from index 2 in ALLOC_RD and
// ALLOC_EV, chain walks visit each block in WALK_RD and WALK_EV: one port reads the link
// memory, the next cycle acts on it. After reset a clearing sweep writes all TABLE_ENTRIES
// (65536) entries with s_tready low; configuration writes are taken throughout.
// A finished result waits in the output register; the next request is taken meanwhile.
module fat_block_allocation_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [15:0] block, [31:16] link_value, [43:32] offset, zero pad
	input  logic [3:0]  s_tuser,   // [2:0] kind, [3] want_position
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [15:0] block_out, [44:16] amount, [60:45] chain_count,
	                               // [63:61] status
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);

	import fbat_pkg::*;

	typedef enum logic [8:0] {
		S_CLEAR    = 9'b000000001,
		S_IDLE     = 9'b000000010,
		S_DISP     = 9'b000000100,
		S_ALLOC_RD = 9'b000001000,
		S_ALLOC_EV = 9'b000010000,
		S_WALK_RD  = 9'b000100000,
		S_WALK_EV  = 9'b001000000,
		S_READ_EV  = 9'b010000000,
		S_FIN      = 9'b100000000
	} state_t;

	state_t state_q;

	logic [2:0]        bsc_q;
	logic [5:0]        fatb_q;
	logic [ADDR_W-1:0] clr_q;

	logic [2:0]  kind_q;
	logic [15:0] blk_q;
	logic [15:0] val_q;
	logic [11:0] off_q;
	logic        wpos_q;

	logic [ENT_W-1:0] cur_q;
	logic [15:0]      n_q;

	logic [15:0] bout_q;
	logic [28:0] amt_q;
	logic [15:0] cnt_q;
	logic [2:0]  st_q;

	logic [63:0] m_tdata_q;
	logic        m_tvalid_q;
	logic        fin_load;

	// Derived sizes
	logic [2:0]       code_c;
	logic [3:0]       sh_c;
	logic [ENT_W-1:0] raw_ents;
	logic [ENT_W-1:0] ents;
	logic             blk_ok;
	logic [ENT_W-1:0] pos_blocks;
	logic [28:0]      pos_amt;
	logic [28:0]      chain_amt;
	logic             freeing;

	// Link memory port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	always_comb begin
		code_c = (bsc_q > MAX_SIZE_CODE) ? MAX_SIZE_CODE : bsc_q;
		sh_c = 4'd8 + {1'b0, code_c};
		raw_ents = {{(ENT_W-6){1'b0}}, fatb_q} << (sh_c - 4'd1);
		ents = (raw_ents > ENT_W'(TABLE_ENTRIES)) ? ENT_W'(TABLE_ENTRIES) : raw_ents;
		blk_ok = {1'b0, blk_q} < ents;
		pos_blocks = {{(ENT_W-6){1'b0}}, fatb_q} + {1'b0, blk_q} - ENT_W'(1);
		pos_amt = 29'({12'd0, pos_blocks} << sh_c) + {17'd0, off_q};
		chain_amt = 29'({13'd0, n_q} << sh_c);
		freeing = (kind_q == KIND_FREE_CHAIN);
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign fin_load = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = cur_q[ADDR_W-1:0];
		ram_wdata = 16'd0;
		ram_raddr = (state_q == S_DISP) ? blk_q[ADDR_W-1:0] : cur_q[ADDR_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = (clr_q == ADDR_W'(1)) ? END_MARK : 16'd0;
			end
			S_DISP: begin
				ram_waddr = blk_q[ADDR_W-1:0];
				if (kind_q == KIND_RELEASE && blk_ok && blk_q > 16'd1) begin
					ram_we = 1'b1;
				end
				if (kind_q == KIND_WRITE && blk_ok && blk_q != 16'd0) begin
					ram_we = 1'b1;
					ram_wdata = val_q;
				end
			end
			S_ALLOC_EV: begin
				ram_we = (ram_rdata == 16'd0);
				ram_wdata = END_MARK;
			end
			S_WALK_EV: begin
				ram_we = freeing;
			end
			default: begin
			end
		endcase
	end

	fbat_ram #(
		.WIDTH(16),
		.DEPTH(TABLE_ENTRIES)
	) u_links (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsc_q <= 3'd0;
			fatb_q <= 6'd1;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BLOCK_SIZE) begin
				bsc_q <= cfg_data[2:0];
			end else begin
				fatb_q <= cfg_data;
			end
		end
	end

	// Request payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser[2:0];
			wpos_q <= s_tuser[3];
			blk_q <= s_tdata[15:0];
			val_q <= s_tdata[31:16];
			off_q <= s_tdata[43:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cur_q <= '0;
			n_q <= 16'd0;
			bout_q <= 16'd0;
			amt_q <= 29'd0;
			cnt_q <= 16'd0;
			st_q <= ST_OK;
			m_tdata_q <= 64'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (fin_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(TABLE_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						bout_q <= 16'd0;
						amt_q <= 29'd0;
						cnt_q <= 16'd0;
						st_q <= ST_OK;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (kind_q)
						KIND_ALLOC: begin
							cur_q <= ENT_W'(2);
							state_q <= S_ALLOC_RD;
						end
						KIND_RELEASE: begin
							state_q <= S_FIN;
							if (!blk_ok) begin
								st_q <= ST_RANGE;
							end else if (blk_q <= 16'd1) begin
								st_q <= ST_PROT;
							end
						end
						KIND_FREE_CHAIN, KIND_COUNT: begin
							cur_q <= {1'b0, blk_q};
							n_q <= 16'd0;
							state_q <= S_WALK_RD;
						end
						KIND_READ: begin
							if (!blk_ok) begin
								st_q <= ST_RANGE;
								state_q <= S_FIN;
							end else if (!wpos_q) begin
								state_q <= S_READ_EV;
							end else if (blk_q == 16'd0) begin
								st_q <= ST_PROT;
								state_q <= S_FIN;
							end else begin
								amt_q <= pos_amt;
								state_q <= S_FIN;
							end
						end
						KIND_WRITE: begin
							state_q <= S_FIN;
							if (!blk_ok) begin
								st_q <= ST_RANGE;
							end else if (blk_q == 16'd0) begin
								st_q <= ST_PROT;
							end
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_ALLOC_RD: begin
					if (cur_q >= ents) begin
						bout_q <= END_MARK;
						st_q <= ST_NOFREE;
						state_q <= S_FIN;
					end else begin
						state_q <= S_ALLOC_EV;
					end
				end
				S_ALLOC_EV: begin
					if (ram_rdata == 16'd0) begin
						bout_q <= cur_q[15:0];
						state_q <= S_FIN;
					end else begin
						cur_q <= cur_q + ENT_W'(1);
						state_q <= S_ALLOC_RD;
					end
				end
				S_WALK_RD: begin
					cnt_q <= n_q;
					amt_q <= freeing ? 29'd0 : chain_amt;
					priority if (cur_q[15:0] == END_MARK) begin
						st_q <= ST_OK;
						state_q <= S_FIN;
					end else if (cur_q >= ents) begin
						st_q <= ST_RANGE;
						state_q <= S_FIN;
					end else if (cur_q == '0 || (freeing && cur_q == ENT_W'(1))) begin
						st_q <= ST_PROT;
						state_q <= S_FIN;
					end else if ({1'b0, n_q} >= ents - ENT_W'(1)) begin
						st_q <= ST_LOOP;
						state_q <= S_FIN;
					end else begin
						state_q <= S_WALK_EV;
					end
				end
				S_WALK_EV: begin
					// Follow the link just read; the entry is cleared in the same cycle if freeing
					cur_q <= {1'b0, ram_rdata};
					n_q <= n_q + 16'd1;
					state_q <= S_WALK_RD;
				end
				S_READ_EV: begin
					bout_q <= ram_rdata;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_load) begin
						m_tdata_q <= {st_q, cnt_q, amt_q, bout_q};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !s_tready)
		else $error("request taken during clearing sweep");

	a_header_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != S_CLEAR) |-> (ram_waddr != '0))
		else $error("header entry written by an operation");

	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_DISP))
		else $error("accepted request not dispatched");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside finish");
`endif

endmodule
